// ===== rtl/gcpl_pkg.sv =====
// Shared constants, angle table and stage types for the grid cell polar lookup core.
package gcpl_pkg;

    localparam int COORD_W           = 10;    // cell_x / cell_y width
    localparam int COORD_HALF_MAX    = 512;   // largest usable grid half width
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ANG_TABLE_LEN     = 24;
    localparam int PRE_SHIFT         = 24;    // offsets are scaled by 2^24 before rotation
    localparam int ANG_W             = 32;    // internal binary angle, 2^32 = one turn
    localparam int BEAR_W            = 16;
    localparam int DIST_W            = 32;
    localparam int SIZE_W            = 16;
    localparam int HALF_W            = 10;
    localparam int H_W               = 14;    // range check width, covers half limits up to 4096
    localparam int SQ_W              = 19;    // square of one offset, at most 2^18
    localparam int R2_W              = 20;    // x^2 + y^2, at most 2^19
    localparam int SSQ_W             = 2 * SIZE_W;
    localparam int N_W               = 52;    // cell_size^2 * r2 < 2^51
    localparam int RW                = N_W + 1;
    localparam int Q_W               = 26;    // floor(sqrt(n)) < 2^26
    localparam int SQRT_LAT          = Q_W + 3;  // sum, multiply, one stage per root bit, round
    localparam int CX_W              = COORD_W + 1;
    localparam int CW                = CX_W + PRE_SHIFT + 2;
    localparam int CFG_IDX_W         = 4;
    localparam int CFG_DATA_W        = 16;
    localparam int S_TDATA_W         = 24;
    localparam int M_TDATA_W         = DIST_W + BEAR_W;

    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HALF_EXTENT = CFG_IDX_W'(1);

    localparam logic [SIZE_W-1:0] CELL_SIZE_RST   = SIZE_W'(256);
    localparam logic [HALF_W-1:0] HALF_EXTENT_RST = HALF_W'(512);

    localparam logic [ANG_W-1:0] ANG_HALF_PI2 = ANG_W'(1) << (ANG_W - 1);        // pi
    localparam logic [ANG_W-1:0] BEAR_RND     = ANG_W'(1) << (ANG_W - BEAR_W - 1);

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [ANG_W-1:0] ANG_STEP [ANG_TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic             valid;
        logic             ok;
        logic [SQ_W-1:0]  xsq;
        logic [SQ_W-1:0]  ysq;
        logic [SSQ_W-1:0] ssq;
    } sq_in_t;

    typedef struct packed {
        logic                   origin;
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic [ANG_W-1:0]       z;
    } cd_in_t;

    typedef struct packed {
        logic           valid;
        logic           ok;
        logic [Q_W:0]   distance;
    } sq_out_t;

    typedef struct packed {
        logic              in_range;
        logic [BEAR_W-1:0] bearing;
        logic [DIST_W-1:0] distance;
    } res_t;

endpackage

// ===== rtl/grid_cell_polar_lookup_core.sv =====
// Grid cell polar lookup: distance and bearing of a grid cell offset from the grid center.
// Takes one cell offset per clock while s_tready is high and returns its metric distance
// (unsigned Q24.8, rounded to nearest), its bearing (16-bit binary angle, 32768 = pi, origin
// gives 0) and an in-range flag; one result per transfer, in order. The latency is set by
// the 26-stage bit-per-stage square root of the distance path; the CORDIC_STAGES bearing
// stages run beside it and do not change the latency. Stalls on the result channel freeze
// the pipeline only once the two-entry output buffer is full and the last pipeline stage
// holds an item. Configuration writes are taken every clock and should be made while no
// item is in flight.
module grid_cell_polar_lookup_core import gcpl_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [9:0] cell_x, [19:10] cell_y, [23:20] zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [31:0] distance, [47:32] bearing
    output logic                  m_tuser,   // [0] in_range
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [SIZE_W-1:0]         cell_size_reg;
    logic [HALF_W-1:0]         half_extent_reg;
    logic signed [COORD_W-1:0] cell_x;
    logic signed [COORD_W-1:0] cell_y;
    logic                      en;
    logic                      skid_ready;
    sq_in_t                    sq_in;
    cd_in_t                    cd_in;
    sq_out_t                   sq_out;
    logic [BEAR_W-1:0]         bearing;
    res_t                      res;
    res_t                      m_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_size_reg   <= CELL_SIZE_RST;
            half_extent_reg <= HALF_EXTENT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CELL_SIZE: begin
                    cell_size_reg <= cfg_data[SIZE_W-1:0];
                end
                REG_HALF_EXTENT: begin
                    half_extent_reg <= cfg_data[HALF_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cell_x = s_tdata[COORD_W-1:0];
    assign cell_y = s_tdata[2*COORD_W-1:COORD_W];

    // whole pipeline moves together; it stops only when its last stage cannot drain
    assign en       = !sq_out.valid || skid_ready;
    assign s_tready = en;

    gcpl_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_tvalid),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .cell_size   (cell_size_reg),
        .half_extent (half_extent_reg),
        .sq_out      (sq_in),
        .cd_out      (cd_in)
    );

    gcpl_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .sq_in   (sq_in),
        .sq_out  (sq_out)
    );

    gcpl_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .aclk    (aclk),
        .en      (en),
        .cd_in   (cd_in),
        .bearing (bearing)
    );

    assign res.in_range = sq_out.ok;
    assign res.bearing  = bearing;
    assign res.distance = DIST_W'(sq_out.distance);

    gcpl_out_skid u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (sq_out.valid),
        .in_ready (skid_ready),
        .in_data  (res),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_data   (m_res)
    );

    assign m_tdata = {m_res.bearing, m_res.distance};
    assign m_tuser = m_res.in_range;

endmodule

// ===== rtl/gcpl_front.sv =====
// Entry stage: squares, range check and CORDIC pre-rotation.
module gcpl_front import gcpl_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic signed [COORD_W-1:0] cell_x,
    input  logic signed [COORD_W-1:0] cell_y,
    input  logic [SIZE_W-1:0]         cell_size,
    input  logic [HALF_W-1:0]         half_extent,
    output sq_in_t                    sq_out,
    output cd_in_t                    cd_out
);

    logic signed [2*COORD_W-1:0] xsq_full;
    logic signed [2*COORD_W-1:0] ysq_full;
    logic signed [H_W-1:0]       h_lim;
    logic signed [H_W-1:0]       x_ext;
    logic signed [H_W-1:0]       y_ext;
    logic signed [CX_W-1:0]      x_wide;
    logic signed [CX_W-1:0]      y_wide;
    logic                        x_neg;
    sq_in_t                      sq_next;
    cd_in_t                      cd_next;
    sq_in_t                      sq_reg;
    cd_in_t                      cd_reg;

    assign xsq_full = cell_x * cell_x;
    assign ysq_full = cell_y * cell_y;

    assign h_lim = (H_W'(half_extent) > H_W'(COORD_HALF_MAX)) ? H_W'(COORD_HALF_MAX)
                                                              : H_W'(half_extent);
    assign x_ext = {{(H_W-COORD_W){cell_x[COORD_W-1]}}, cell_x};
    assign y_ext = {{(H_W-COORD_W){cell_y[COORD_W-1]}}, cell_y};

    assign x_wide = {cell_x[COORD_W-1], cell_x};
    assign y_wide = {cell_y[COORD_W-1], cell_y};
    assign x_neg  = cell_x[COORD_W-1];

    always_comb begin
        sq_next.valid = in_valid;
        sq_next.ok    = (x_ext >= -h_lim) && (x_ext <= h_lim - H_W'(1))
                     && (y_ext >= -h_lim) && (y_ext <= h_lim - H_W'(1));
        sq_next.xsq   = xsq_full[SQ_W-1:0];
        sq_next.ysq   = ysq_full[SQ_W-1:0];
        sq_next.ssq   = cell_size * cell_size;

        // left half plane: rotate by pi first
        cd_next.origin = (cell_x == '0) && (cell_y == '0);
        cd_next.x      = x_neg ? -x_wide : x_wide;
        cd_next.y      = x_neg ? -y_wide : y_wide;
        cd_next.z      = x_neg ? ANG_HALF_PI2 : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_reg.valid <= 1'b0;
        end else if (en) begin
            sq_reg.valid <= sq_next.valid;
        end
        if (en) begin
            sq_reg.ok  <= sq_next.ok;
            sq_reg.xsq <= sq_next.xsq;
            sq_reg.ysq <= sq_next.ysq;
            sq_reg.ssq <= sq_next.ssq;
            cd_reg     <= cd_next;
        end
    end

    assign sq_out = sq_reg;
    assign cd_out = cd_reg;

endmodule

// ===== rtl/gcpl_sqrt.sv =====
// Distance path: r^2 * s^2 followed by a one-bit-per-stage rounded square root.
module gcpl_sqrt import gcpl_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,
    input  sq_in_t  sq_in,
    output sq_out_t sq_out
);

    logic [SQRT_LAT-1:0] valid_reg;
    logic [SQRT_LAT-1:0] ok_reg;
    logic [R2_W-1:0]     r2_reg;
    logic [SSQ_W-1:0]    ssq_reg;
    logic [N_W-1:0]      n_next;
    logic [N_W-1:0]      n_reg;
    logic [N_W-1:0]      rem_reg [Q_W];
    logic [Q_W-1:0]      q_reg   [Q_W];
    logic                rnd;
    logic [Q_W:0]        dist_next;
    logic [Q_W:0]        dist_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[SQRT_LAT-2:0], sq_in.valid};
        end
    end

    assign n_next = ssq_reg * r2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ok_reg  <= {ok_reg[SQRT_LAT-2:0], sq_in.ok};
            r2_reg  <= R2_W'(sq_in.xsq) + R2_W'(sq_in.ysq);
            ssq_reg <= sq_in.ssq;
            n_reg   <= n_next;
        end
    end

    // restoring square root, most significant root bit first
    for (genvar k = 0; k < Q_W; k++) begin : g_bit
        localparam int B = Q_W - 1 - k;
        logic [N_W-1:0] rem_in;
        logic [Q_W-1:0] q_in;
        logic [RW-1:0]  d;
        logic           take;

        if (k == 0) begin : g_first
            assign rem_in = n_reg;
            assign q_in   = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        // (q + 2^B)^2 - q^2
        assign d    = (RW'(q_in) << (B + 1)) + (RW'(1) << (2 * B));
        assign take = ({1'b0, rem_in} >= d);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= take ? N_W'({1'b0, rem_in} - d) : rem_in;
                q_reg[k]   <= take ? (q_in | (Q_W'(1) << B)) : q_in;
            end
        end
    end

    // round to nearest: remainder above the root means the upper neighbor is closer
    assign rnd       = rem_reg[Q_W-1] > N_W'(q_reg[Q_W-1]);
    assign dist_next = {1'b0, q_reg[Q_W-1]} + (Q_W+1)'(rnd);

    always_ff @(posedge aclk) begin
        if (en) begin
            dist_reg <= dist_next;
        end
    end

    assign sq_out.valid    = valid_reg[SQRT_LAT-1];
    assign sq_out.ok       = ok_reg[SQRT_LAT-1];
    assign sq_out.distance = dist_reg;

endmodule

// ===== rtl/gcpl_cordic.sv =====
// Bearing path: pipelined vectoring CORDIC, rounding to 16 bits, delay to match the distance path.
module gcpl_cordic import gcpl_pkg::*; #(
    parameter int STAGES = CORDIC_STAGES_DEF
) (
    input  logic              aclk,
    input  logic              en,
    input  cd_in_t            cd_in,
    output logic [BEAR_W-1:0] bearing
);

    localparam int DLY = SQRT_LAT - STAGES;

    logic signed [CW-1:0] x_reg [STAGES];
    logic signed [CW-1:0] y_reg [STAGES];
    logic [ANG_W-1:0]     z_reg [STAGES];
    logic [STAGES-1:0]    org_reg;
    logic [ANG_W-1:0]     z_rnd;
    logic [BEAR_W-1:0]    bear_next;
    logic [BEAR_W-1:0]    b_reg [DLY];

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [CW-1:0] x_in;
        logic signed [CW-1:0] y_in;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic [ANG_W-1:0]     z_in;
        logic                 org_in;
        logic                 y_pos;

        if (i == 0) begin : g_first
            assign x_in   = {{(CW-CX_W-PRE_SHIFT){cd_in.x[CX_W-1]}}, cd_in.x,
                             {PRE_SHIFT{1'b0}}};
            assign y_in   = {{(CW-CX_W-PRE_SHIFT){cd_in.y[CX_W-1]}}, cd_in.y,
                             {PRE_SHIFT{1'b0}}};
            assign z_in   = cd_in.z;
            assign org_in = cd_in.origin;
        end else begin : g_rest
            assign x_in   = x_reg[i-1];
            assign y_in   = y_reg[i-1];
            assign z_in   = z_reg[i-1];
            assign org_in = org_reg[i-1];
        end

        assign xs    = x_in >>> i;
        assign ys    = y_in >>> i;
        assign y_pos = !y_in[CW-1] && (y_in != '0);

        always_ff @(posedge aclk) begin
            if (en) begin
                if (y_pos) begin
                    x_reg[i] <= x_in + ys;
                    y_reg[i] <= y_in - xs;
                    z_reg[i] <= z_in + ANG_STEP[i];
                end else begin
                    x_reg[i] <= x_in - ys;
                    y_reg[i] <= y_in + xs;
                    z_reg[i] <= z_in - ANG_STEP[i];
                end
                org_reg[i] <= org_in;
            end
        end
    end

    assign z_rnd     = z_reg[STAGES-1] + BEAR_RND;
    assign bear_next = org_reg[STAGES-1] ? '0 : z_rnd[ANG_W-1:ANG_W-BEAR_W];

    always_ff @(posedge aclk) begin
        if (en) begin
            b_reg[0] <= bear_next;
            for (int j = 1; j < DLY; j++) begin
                b_reg[j] <= b_reg[j-1];
            end
        end
    end

    assign bearing = b_reg[DLY-1];

endmodule

// ===== rtl/gcpl_out_skid.sv =====
// Two-entry output buffer between the pipeline and the result channel.
module gcpl_out_skid import gcpl_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  res_t in_data,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_data
);

    logic main_valid_reg;
    logic skid_valid_reg;
    res_t main_data_reg;
    res_t skid_data_reg;
    logic pop;
    logic push;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && !skid_valid_reg;
    assign pop      = main_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                if (skid_valid_reg) begin
                    skid_valid_reg <= 1'b0;
                end else begin
                    main_valid_reg <= push;
                end
            end else if (!main_valid_reg) begin
                main_valid_reg <= push;
            end else if (push) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && skid_valid_reg) begin
            main_data_reg <= skid_data_reg;
        end else if (pop || !main_valid_reg) begin
            main_data_reg <= in_data;
        end
        if (push && main_valid_reg && !pop) begin
            skid_data_reg <= in_data;
        end
    end

    assign m_valid = main_valid_reg;
    assign m_data  = main_data_reg;

endmodule
